/* rtl/csref_pkg.sv */
// Shared constants and types of the curvature speed reference unit.
`timescale 1ns / 1ps

package csref_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int FIELD_W       = 32;
   localparam int VALUE_W       = 31;
   localparam int CSR_IDX_W     = 2;
   localparam int REQ_DATA_W    = 6 * FIELD_W;
   localparam int RSP_DATA_W    = 64;

   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LOW   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_HIGH  = 2'd3;

   localparam logic [VALUE_W-1:0] RADIUS_LOW_RST  = 31'd1310720;
   localparam logic [VALUE_W-1:0] RADIUS_HIGH_RST = 31'd6553600;
   localparam logic [VALUE_W-1:0] SPEED_LOW_RST   = 31'd2621440;
   localparam logic [VALUE_W-1:0] SPEED_HIGH_RST  = 31'd6553600;
   localparam logic [VALUE_W-1:0] VALUE_MAX       = '1;

   // Ten degrees in radians with 32 fraction bits.
   localparam longint unsigned HEADING_TOL_Q32 = 64'd749613206;

   localparam int ROOT_W = 34;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int QUOT_W = VALUE_W;

   typedef struct packed {
      logic [VALUE_W-1:0] radius;
      logic [VALUE_W-1:0] den;
      logic               above;
      logic               blend;
      logic               span_neg;
      logic               boost;
   } blend_tag_type;

endpackage

/* rtl/curvature_speed_reference_unit.sv */
// Pipelined curvature radius and reference speed unit.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// req_      in         tdata[191:0]: coef_linear, coef_square, coef_cube, position_x,
//                      track_error, heading_error (32 bits each, lowest first)
// rsp_      out        tdata[63:0]: ref_speed[30:0], curve_radius[61:31], boosted[62]
// csr_      in         csr_we, csr_index[1:0], csr_wdata[30:0]
//
// One transfer is accepted every cycle while the result side does not stall; the pipeline holds
// the 34-stage square root and the two 31-stage dividers, one result bit per stage.
// Reset is synchronous and clears the valid bits and the control registers to their defaults.
// A stall at the result side freezes the pipeline only while its last stage is full.

module curvature_speed_reference_unit #(
   parameter int FRAC_BITS = csref_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // coef_linear, coef_square, coef_cube, position_x, track_error, heading_error
   input  logic [csref_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // ref_speed, curve_radius, boosted, one zero pad bit
   output logic [csref_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [csref_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csref_pkg::VALUE_W-1:0]        csr_wdata
);

   localparam int F      = FRAC_BITS;
   localparam int VW     = csref_pkg::VALUE_W;
   localparam int ROOT_W = csref_pkg::ROOT_W;
   localparam int RAD_W  = csref_pkg::RAD_W;
   localparam int QUOT_W = csref_pkg::QUOT_W;
   localparam int QW     = 63 - F;
   localparam int KW     = QW + 32;
   localparam int KSW    = KW - F;
   localparam int D1W    = 66 - F;
   localparam int D2W    = 65 - F;
   localparam int SW     = 67 - F;
   localparam int NW     = SW + ROOT_W;
   localparam int PHW    = NW - 32;
   localparam int REMW   = ROOT_W + 1;
   localparam int PW     = 2 * VW;

   localparam int SQ0 = 9;
   localparam int M1S = SQ0 + ROOT_W;
   localparam int M2S = M1S + 1;
   localparam int DV0 = M2S + 1;
   localparam int B0S = DV0 + QUOT_W;
   localparam int B1S = B0S + 1;
   localparam int DW0 = B1S + 1;
   localparam int VS  = DW0 + QUOT_W;
   localparam int NST = VS + 1;

   localparam longint unsigned HeadTolWide =
      (csref_pkg::HEADING_TOL_Q32 + (64'd1 << (31 - F))) >> (32 - F);
   localparam logic [31:0]    HEAD_TOL = 32'(HeadTolWide);
   localparam logic [31:0]    CTE_TOL  = 32'(64'd1 << F);
   localparam logic [KSW-1:0] K_CAP    = KSW'(64'd1 << 33);
   localparam logic [D1W-1:0] D1_CAP   = D1W'(64'd1 << 33);
   localparam logic [SW-1:0]  S_ONE    = SW'(64'd1 << F);

   function automatic logic [31:0] abs_value(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   logic [VW-1:0] radius_low_ff, radius_high_ff, speed_low_ff, speed_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_low_ff  <= csref_pkg::RADIUS_LOW_RST;
         radius_high_ff <= csref_pkg::RADIUS_HIGH_RST;
         speed_low_ff   <= csref_pkg::SPEED_LOW_RST;
         speed_high_ff  <= csref_pkg::SPEED_HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            csref_pkg::REG_RADIUS_LOW:  radius_low_ff  <= csr_wdata;
            csref_pkg::REG_RADIUS_HIGH: radius_high_ff <= csr_wdata;
            csref_pkg::REG_SPEED_LOW:   speed_low_ff   <= csr_wdata;
            csref_pkg::REG_SPEED_HIGH:  speed_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [NST-1:0] vld_ff;
   logic           rsp_tvalid_ff;
   logic           out_ld, adv;

   assign out_ld     = !rsp_tvalid_ff || rsp_tready;
   assign adv        = !vld_ff[NST-1] || out_ld;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[NST-2:0], req_tvalid};
         end
         if (out_ld) begin
            rsp_tvalid_ff <= vld_ff[NST-1];
         end
      end
   end

   // Stage 0: magnitudes, product signs and the error window test.
   logic [31:0] fld_c2, fld_c3, fld_x, fld_cte, fld_epsi;
   assign fld_c2   = req_tdata[63:32];
   assign fld_c3   = req_tdata[95:64];
   assign fld_x    = req_tdata[127:96];
   assign fld_cte  = req_tdata[159:128];
   assign fld_epsi = req_tdata[191:160];

   logic signed [31:0] s0_c1_ff, s0_c2_ff;
   logic [31:0]        s0_c2m_ff, s0_c3m_ff, s0_xm_ff;
   logic               s0_pneg_ff, s0_qneg_ff, s0_xneg_ff, s0_ok_ff, s0_ok_in;

   assign s0_ok_in = (abs_value(fld_cte) < CTE_TOL) && (abs_value(fld_epsi) < HEAD_TOL);

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_c1_ff   <= req_tdata[31:0];
         s0_c2_ff   <= fld_c2;
         s0_c2m_ff  <= abs_value(fld_c2);
         s0_c3m_ff  <= abs_value(fld_c3);
         s0_xm_ff   <= abs_value(fld_x);
         s0_pneg_ff <= fld_c2[31] ^ fld_x[31];
         s0_qneg_ff <= fld_c3[31] ^ fld_x[31];
         s0_xneg_ff <= fld_x[31];
         s0_ok_ff   <= s0_ok_in;
      end
   end

   // Stage 1: c2*x and c3*x.
   logic signed [31:0] s1_c1_ff, s1_c2_ff;
   logic [63:0]        s1_pc2_ff, s1_pc3_ff;
   logic [31:0]        s1_xm_ff;
   logic               s1_pneg_ff, s1_qneg_ff, s1_xneg_ff, s1_ok_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pc2_ff  <= 64'(s0_c2m_ff) * 64'(s0_xm_ff);
         s1_pc3_ff  <= 64'(s0_c3m_ff) * 64'(s0_xm_ff);
         s1_c1_ff   <= s0_c1_ff;
         s1_c2_ff   <= s0_c2_ff;
         s1_xm_ff   <= s0_xm_ff;
         s1_pneg_ff <= s0_pneg_ff;
         s1_qneg_ff <= s0_qneg_ff;
         s1_xneg_ff <= s0_xneg_ff;
         s1_ok_ff   <= s0_ok_ff;
      end
   end

   // Stage 2: scale down, start q*x as two partial products.
   logic [QW-1:0] s2_qm_in, s2_pm_in;
   assign s2_qm_in = s1_pc3_ff[F +: QW];
   assign s2_pm_in = s1_pc2_ff[F +: QW];

   logic signed [31:0] s2_c1_ff, s2_c2_ff;
   logic [QW-1:0]      s2_qm_ff, s2_pm_ff, s2_khi_ff;
   logic [63:0]        s2_klo_ff;
   logic               s2_pneg_ff, s2_qneg_ff, s2_kneg_ff, s2_ok_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_klo_ff  <= 64'(s2_qm_in[31:0]) * 64'(s1_xm_ff);
         s2_khi_ff  <= QW'(s2_qm_in[QW-1:32]) * QW'(s1_xm_ff);
         s2_qm_ff   <= s2_qm_in;
         s2_pm_ff   <= s2_pm_in;
         s2_c1_ff   <= s1_c1_ff;
         s2_c2_ff   <= s1_c2_ff;
         s2_pneg_ff <= s1_pneg_ff;
         s2_qneg_ff <= s1_qneg_ff;
         s2_kneg_ff <= s1_qneg_ff ^ s1_xneg_ff;
         s2_ok_ff   <= s1_ok_ff;
      end
   end

   // Stage 3: finish q*x with its cap, apply signs to q and p.
   logic [KW-1:0]  s3_kprod;
   logic [KSW-1:0] s3_kshift;
   logic [33:0]    s3_km_in;
   assign s3_kprod  = KW'(s2_klo_ff) + {s2_khi_ff, 32'd0};
   assign s3_kshift = s3_kprod[KW-1:F];
   assign s3_km_in  = (s3_kshift > K_CAP) ? 34'(K_CAP) : s3_kshift[33:0];

   logic signed [31:0] s3_c1_ff, s3_c2_ff;
   logic signed [QW:0] s3_qs_ff, s3_ps_ff;
   logic [33:0]        s3_km_ff;
   logic               s3_kneg_ff, s3_ok_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_km_ff   <= s3_km_in;
         s3_qs_ff   <= s2_qneg_ff ? -{1'b0, s2_qm_ff} : {1'b0, s2_qm_ff};
         s3_ps_ff   <= s2_pneg_ff ? -{1'b0, s2_pm_ff} : {1'b0, s2_pm_ff};
         s3_c1_ff   <= s2_c1_ff;
         s3_c2_ff   <= s2_c2_ff;
         s3_kneg_ff <= s2_kneg_ff;
         s3_ok_ff   <= s2_ok_ff;
      end
   end

   // Stage 4: partial first derivative, 3k, second derivative.
   logic signed [35:0]  s4_ks;
   assign s4_ks = s3_kneg_ff ? -36'(s3_km_ff) : 36'(s3_km_ff);

   logic signed [D1W-1:0] s4_part_ff;
   logic signed [35:0]    s4_k3_ff;
   logic signed [D2W:0]   s4_d2_ff;
   logic                  s4_ok_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_part_ff <= D1W'(s3_c1_ff) + (D1W'(s3_ps_ff) <<< 1);
         s4_k3_ff   <= s4_ks + (s4_ks <<< 1);
         s4_d2_ff   <= ((D2W + 1)'(s3_c2_ff) <<< 1) + ((D2W + 1)'(s3_qs_ff) <<< 2)
                     + ((D2W + 1)'(s3_qs_ff) <<< 1);
         s4_ok_ff   <= s3_ok_ff;
      end
   end

   // Stage 5: clamp |f'| and take |f''|.
   logic signed [D1W-1:0] s5_d1;
   logic [D1W-1:0]        s5_d1abs;
   assign s5_d1    = s4_part_ff + D1W'(s4_k3_ff);
   assign s5_d1abs = s5_d1[D1W-1] ? D1W'(-s5_d1) : D1W'(s5_d1);

   logic [33:0]    s5_d1m_ff;
   logic [D2W-1:0] s5_a_ff;
   logic           s5_ok_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_d1m_ff <= (s5_d1abs > D1_CAP) ? 34'(D1_CAP) : s5_d1abs[33:0];
         s5_a_ff   <= s4_d2_ff[D2W] ? D2W'(-s4_d2_ff) : D2W'(s4_d2_ff);
         s5_ok_ff  <= s4_ok_ff;
      end
   end

   // Stages 6 to 8: f'^2 from three half-width products, then the term 1 + f'^2.
   logic [33:0]    s6_ll_ff, s6_lh_ff, s6_hh_ff;
   logic [D2W-1:0] s6_a_ff, s7_a_ff, s8_a_ff;
   logic           s6_ok_ff, s7_ok_ff, s8_ok_ff;
   logic [66:0]    s7_sq_ff;
   logic [SW-1:0]  s8_s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_ll_ff <= 34'(s5_d1m_ff[16:0]) * 34'(s5_d1m_ff[16:0]);
         s6_lh_ff <= 34'(s5_d1m_ff[16:0]) * 34'(s5_d1m_ff[33:17]);
         s6_hh_ff <= 34'(s5_d1m_ff[33:17]) * 34'(s5_d1m_ff[33:17]);
         s6_a_ff  <= s5_a_ff;
         s6_ok_ff <= s5_ok_ff;
         s7_sq_ff <= 67'(s6_ll_ff) + (67'(s6_lh_ff) << 18) + (67'(s6_hh_ff) << 34);
         s7_a_ff  <= s6_a_ff;
         s7_ok_ff <= s6_ok_ff;
         s8_s_ff  <= SW'(s7_sq_ff >> F) + S_ONE;
         s8_a_ff  <= s7_a_ff;
         s8_ok_ff <= s7_ok_ff;
      end
   end

   // Square root of S scaled up by F bits, one root bit per stage.
   logic [SW-1:0]     sq_s_ff    [ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   logic [ROOT_W-1:0] sq_root_in [ROOT_W];
   logic [REMW-1:0]   sq_rem_ff  [ROOT_W];
   logic [REMW-1:0]   sq_rem_in  [ROOT_W];
   logic [D2W-1:0]    sq_a_ff    [ROOT_W];
   logic              sq_ok_ff   [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      localparam int PairIdx = ROOT_W - 1 - j;
      logic [SW-1:0]     s_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REMW-1:0]   rem_prev;
      logic [D2W-1:0]    a_prev;
      logic              ok_prev;
      logic [RAD_W-1:0]  rad;
      logic [REMW+1:0]   pre, trial;
      logic              ge;

      if (j == 0) begin : g_head
         assign s_prev    = s8_s_ff;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign a_prev    = s8_a_ff;
         assign ok_prev   = s8_ok_ff;
      end else begin : g_body
         assign s_prev    = sq_s_ff[j-1];
         assign root_prev = sq_root_ff[j-1];
         assign rem_prev  = sq_rem_ff[j-1];
         assign a_prev    = sq_a_ff[j-1];
         assign ok_prev   = sq_ok_ff[j-1];
      end

      always_comb begin
         rad           = RAD_W'({s_prev, {F{1'b0}}});
         pre           = {rem_prev, rad[2*PairIdx +: 2]};
         trial         = (REMW + 2)'({root_prev, 2'b01});
         ge            = pre >= trial;
         sq_rem_in[j]  = ge ? REMW'(pre - trial) : REMW'(pre);
         sq_root_in[j] = {root_prev[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_s_ff[j]    <= s_prev;
            sq_root_ff[j] <= sq_root_in[j];
            sq_rem_ff[j]  <= sq_rem_in[j];
            sq_a_ff[j]    <= a_prev;
            sq_ok_ff[j]   <= ok_prev;
         end
      end
   end

   // Numerator S*sqrt(S) in two partial products.
   logic [65:0]    m1_pl_ff;
   logic [PHW-1:0] m1_ph_ff;
   logic [NW-1:0]  m2_num_ff;
   logic [D2W-1:0] m1_a_ff, m2_a_ff;
   logic           m1_ok_ff, m2_ok_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_pl_ff  <= 66'(sq_s_ff[ROOT_W-1][31:0]) * 66'(sq_root_ff[ROOT_W-1]);
         m1_ph_ff  <= PHW'(sq_s_ff[ROOT_W-1][SW-1:32]) * PHW'(sq_root_ff[ROOT_W-1]);
         m1_a_ff   <= sq_a_ff[ROOT_W-1];
         m1_ok_ff  <= sq_ok_ff[ROOT_W-1];
         m2_num_ff <= NW'(m1_pl_ff) + {m1_ph_ff, 32'd0};
         m2_a_ff   <= m1_a_ff;
         m2_ok_ff  <= m1_ok_ff;
      end
   end

   // Radius division, one quotient bit per stage.
   logic [NW-1:0]     dv_rem_ff [QUOT_W];
   logic [NW-1:0]     dv_rem_in [QUOT_W];
   logic [QUOT_W-1:0] dv_q_ff   [QUOT_W];
   logic [D2W-1:0]    dv_a_ff   [QUOT_W];
   logic              dv_sat_ff [QUOT_W];
   logic              dv_ok_ff  [QUOT_W];

   for (genvar j = 0; j < QUOT_W; j++) begin : g_rdiv
      localparam int Bit = QUOT_W - 1 - j;
      logic [NW-1:0]     rem_prev, trial;
      logic [QUOT_W-1:0] q_prev;
      logic [D2W-1:0]    a_prev;
      logic              sat_prev, ok_prev, ge;

      if (j == 0) begin : g_head
         assign rem_prev = m2_num_ff;
         assign q_prev   = '0;
         assign a_prev   = m2_a_ff;
         assign sat_prev = (m2_a_ff == '0) || ((NW'(m2_a_ff) << QUOT_W) <= m2_num_ff);
         assign ok_prev  = m2_ok_ff;
      end else begin : g_body
         assign rem_prev = dv_rem_ff[j-1];
         assign q_prev   = dv_q_ff[j-1];
         assign a_prev   = dv_a_ff[j-1];
         assign sat_prev = dv_sat_ff[j-1];
         assign ok_prev  = dv_ok_ff[j-1];
      end

      assign trial        = NW'(a_prev) << Bit;
      assign ge           = rem_prev >= trial;
      assign dv_rem_in[j] = ge ? (rem_prev - trial) : rem_prev;

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_q_ff[j]   <= {q_prev[QUOT_W-2:0], ge};
            dv_a_ff[j]   <= a_prev;
            dv_sat_ff[j] <= sat_prev;
            dv_ok_ff[j]  <= ok_prev;
         end
      end
   end

   // Speed selection and boost window.
   logic [VW-1:0] b0_r;
   logic [31:0]   b0_span;
   assign b0_r    = dv_sat_ff[QUOT_W-1] ? csref_pkg::VALUE_MAX : dv_q_ff[QUOT_W-1];
   assign b0_span = 32'(speed_high_ff) - 32'(speed_low_ff);

   csref_pkg::blend_tag_type b0_tag_ff, b0_tag_in, b1_tag_ff;
   logic [VW-1:0]            b0_diff_ff, b0_spanm_ff;
   logic [PW-1:0]            b1_prod_ff;

   always_comb begin
      b0_tag_in.radius   = b0_r;
      b0_tag_in.den      = radius_high_ff - radius_low_ff;
      b0_tag_in.above    = b0_r > radius_high_ff;
      b0_tag_in.blend    = (b0_r > radius_low_ff) && !(b0_r > radius_high_ff);
      b0_tag_in.span_neg = b0_span[31];
      b0_tag_in.boost    = dv_ok_ff[QUOT_W-1] && (33'(b0_r) < {radius_low_ff, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_tag_ff   <= b0_tag_in;
         b0_diff_ff  <= b0_r - radius_low_ff;
         b0_spanm_ff <= VW'(abs_value(b0_span));
         b1_tag_ff   <= b0_tag_ff;
         b1_prod_ff  <= PW'(b0_diff_ff) * PW'(b0_spanm_ff);
      end
   end

   // Blend division, one quotient bit per stage.
   logic [PW-1:0]            dw_rem_ff [QUOT_W];
   logic [PW-1:0]            dw_rem_in [QUOT_W];
   logic [QUOT_W-1:0]        dw_q_ff   [QUOT_W];
   csref_pkg::blend_tag_type dw_tag_ff [QUOT_W];

   for (genvar j = 0; j < QUOT_W; j++) begin : g_bdiv
      localparam int Bit = QUOT_W - 1 - j;
      logic [PW-1:0]            rem_prev, trial;
      logic [QUOT_W-1:0]        q_prev;
      csref_pkg::blend_tag_type tag_prev;
      logic                     ge;

      if (j == 0) begin : g_head
         assign rem_prev = b1_prod_ff;
         assign q_prev   = '0;
         assign tag_prev = b1_tag_ff;
      end else begin : g_body
         assign rem_prev = dw_rem_ff[j-1];
         assign q_prev   = dw_q_ff[j-1];
         assign tag_prev = dw_tag_ff[j-1];
      end

      assign trial        = PW'(tag_prev.den) << Bit;
      assign ge           = rem_prev >= trial;
      assign dw_rem_in[j] = ge ? (rem_prev - trial) : rem_prev;

      always_ff @(posedge clock) begin
         if (adv) begin
            dw_rem_ff[j] <= dw_rem_in[j];
            dw_q_ff[j]   <= {q_prev[QUOT_W-2:0], ge};
            dw_tag_ff[j] <= tag_prev;
         end
      end
   end

   csref_pkg::blend_tag_type vs_tag;
   logic [QUOT_W-1:0]        vs_quot;
   logic [VW-1:0]            vs_v_in, vs_v_ff, vs_r_ff;
   logic                     vs_boost_ff;

   assign vs_tag  = dw_tag_ff[QUOT_W-1];
   assign vs_quot = dw_q_ff[QUOT_W-1];

   always_comb begin
      if (vs_tag.blend) begin
         vs_v_in = vs_tag.span_neg ? (speed_low_ff - vs_quot) : (speed_low_ff + vs_quot);
      end else if (vs_tag.above) begin
         vs_v_in = speed_high_ff;
      end else begin
         vs_v_in = speed_low_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vs_v_ff     <= vs_v_in;
         vs_r_ff     <= vs_tag.radius;
         vs_boost_ff <= vs_tag.boost;
      end
   end

   // Output register with the 1.25 speed-up.
   logic [31:0]                      out_vb;
   logic [VW-1:0]                    out_speed;
   logic [csref_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   assign out_vb    = 32'(vs_v_ff) + 32'(vs_v_ff >> 2);
   assign out_speed = !vs_boost_ff ? vs_v_ff
                    : (out_vb[31] ? csref_pkg::VALUE_MAX : out_vb[VW-1:0]);

   always_ff @(posedge clock) begin
      if (out_ld) begin
         rsp_tdata_ff <= {1'b0, vs_boost_ff, vs_r_ff, out_speed};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (vld_ff[NST-1] && rsp_tvalid && !rsp_tready))
      else $error("pipeline stalled with room to advance");

   a_boost_small_radius : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[62]) |-> (33'(rsp_tdata[61:31]) < {radius_low_ff, 2'b00}))
      else $error("boost applied outside the small radius window");

   a_straight_speed : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[62] && (rsp_tdata[61:31] > radius_high_ff))
      |-> (rsp_tdata[30:0] == speed_high_ff))
      else $error("large radius without maximum speed");

endmodule
